/* design/ohlc_pkg.sv */
// Package for the multichannel OHLC tracker.
// Holds the channel count, field widths, the reset bar width and the shared value types.
// No dependencies.
package ohlc_pkg;

    localparam int CHANNELS = 7;
    localparam int SAMPLE_W = 16;
    localparam int POS_W = 8;
    localparam int CH_W = 3;
    localparam int BAR_W = 8;
    localparam logic [BAR_W-1:0] BAR_WIDTH_RESET = 8'd50;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample open_value;
        t_sample high_value;
        t_sample low_value;
        t_sample close_value;
    } t_ohlc;

    typedef struct packed {
        logic [POS_W-1:0] open_pos;
        logic [POS_W-1:0] high_pos;
        logic [POS_W-1:0] low_pos;
        logic [POS_W-1:0] close_pos;
    } t_pos;

endpackage

/* design/ohlc_frame_if.sv */
// Input channel of the OHLC tracker: one sensor frame per item.
// Depends on ohlc_pkg for the sample type.
interface ohlc_frame_if;
    import ohlc_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_0;
    t_sample sample_1;
    t_sample sample_2;
    t_sample sample_3;
    t_sample sample_4;
    t_sample sample_5;
    t_sample sample_6;
    logic    opens_run;
    logic    closes_run;

    modport source (
        output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5, sample_6,
        output opens_run, closes_run,
        input  ready
    );
    modport sink (
        input  valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5, sample_6,
        input  opens_run, closes_run,
        output ready
    );
endinterface

/* design/ohlc_cfg_if.sv */
// Configuration write channel of the OHLC tracker, carrying the bar width.
// Depends on ohlc_pkg for the register width.
interface ohlc_cfg_if;
    import ohlc_pkg::*;

    logic             valid;
    logic             ready;
    logic [BAR_W-1:0] bar_width;

    modport source (output valid, bar_width, input ready);
    modport sink (input valid, bar_width, output ready);
endinterface

/* design/ohlc_result_if.sv */
// Result channel of the OHLC tracker: one channel summary per item.
// Depends on ohlc_pkg for the value and position widths.
interface ohlc_result_if;
    import ohlc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  channel;
    t_sample          open_value;
    t_sample          high_value;
    t_sample          low_value;
    t_sample          close_value;
    logic [POS_W-1:0] open_pos;
    logic [POS_W-1:0] high_pos;
    logic [POS_W-1:0] low_pos;
    logic [POS_W-1:0] close_pos;
    logic             last_of_run;

    modport source (
        output valid, channel, open_value, high_value, low_value, close_value,
        output open_pos, high_pos, low_pos, close_pos, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, channel, open_value, high_value, low_value, close_value,
        input  open_pos, high_pos, low_pos, close_pos, last_of_run,
        output ready
    );
endinterface

/* design/multichannel_ohlc_tracker.sv */
// Multichannel OHLC tracker: per-channel open, high, low and close over runs of frames.
// Frames that do not close a run are accepted every cycle; a closing frame is taken once the
// previous run's results have left the snapshot buffer, and its seven results follow in channel
// order from a registered output stage, each held while the result channel is not ready.
// Reset clears the per-channel running state to zero, empties the snapshot buffer and sets the bar width to 50.
// Depends on ohlc_pkg, the three channel interfaces, ohlc_chan_update and ohlc_result_fmt.
module multichannel_ohlc_tracker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ohlc_frame_if.sink     i_frame,
    ohlc_cfg_if.sink       i_cfg,
    ohlc_result_if.source  o_result
);
    import ohlc_pkg::*;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    logic [BAR_W-1:0] r_bar_width;
    t_ohlc            r_state [CHANNELS];
    t_ohlc            n_state [CHANNELS];
    t_ohlc            r_snap  [CHANNELS];
    t_sample          smp     [CHANNELS];
    logic             r_busy;
    logic [CH_W-1:0]  r_idx;
    logic             r_out_valid;
    logic [CH_W-1:0]  r_out_ch;
    t_ohlc            r_out_vals;
    t_pos             r_out_pos;
    logic             r_out_last;
    t_pos             fmt_pos;
    logic             frame_acc;
    logic             snap_load;
    logic             out_load;
    logic             drain_last;

    assign smp[0] = i_frame.sample_0;
    assign smp[1] = i_frame.sample_1;
    assign smp[2] = i_frame.sample_2;
    assign smp[3] = i_frame.sample_3;
    assign smp[4] = i_frame.sample_4;
    assign smp[5] = i_frame.sample_5;
    assign smp[6] = i_frame.sample_6;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_width <= BAR_WIDTH_RESET;
        end else if (i_cfg.valid) begin
            r_bar_width <= i_cfg.bar_width;
        end
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        ohlc_chan_update u_update (
            .i_sample (smp[c]),
            .i_opens  (i_frame.opens_run),
            .i_closes (i_frame.closes_run),
            .i_cur    (r_state[c]),
            .o_next   (n_state[c])
        );
    end

    assign out_load   = r_busy && (!r_out_valid || o_result.ready);
    assign drain_last = out_load && (r_idx == LAST_CH);
    assign i_frame.ready = !i_frame.closes_run || !r_busy || drain_last;
    assign frame_acc  = i_frame.valid && i_frame.ready;
    assign snap_load  = frame_acc && i_frame.closes_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_state[c] <= '0;
            end
        end else if (frame_acc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_load) begin
            r_snap <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (snap_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (out_load) begin
            r_busy <= (r_idx != LAST_CH);
            r_idx  <= r_idx + 1'b1;
        end
    end

    ohlc_result_fmt u_fmt (
        .i_vals      (r_snap[r_idx]),
        .i_bar_width (r_bar_width),
        .o_pos       (fmt_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ch   <= r_idx;
            r_out_vals <= r_snap[r_idx];
            r_out_pos  <= fmt_pos;
            r_out_last <= (r_idx == LAST_CH);
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.channel     = r_out_ch;
    assign o_result.open_value  = r_out_vals.open_value;
    assign o_result.high_value  = r_out_vals.high_value;
    assign o_result.low_value   = r_out_vals.low_value;
    assign o_result.close_value = r_out_vals.close_value;
    assign o_result.open_pos    = r_out_pos.open_pos;
    assign o_result.high_pos    = r_out_pos.high_pos;
    assign o_result.low_pos     = r_out_pos.low_pos;
    assign o_result.close_pos   = r_out_pos.close_pos;
    assign o_result.last_of_run = r_out_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= LAST_CH))
        else $error("result index beyond the last channel");

    a_snap_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        snap_load |-> (!r_busy || drain_last))
        else $error("closing frame taken while the snapshot buffer is still draining");

    a_channel_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_result.valid && o_result.channel == $past(r_idx)))
        else $error("result channel does not follow the drain index");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.last_of_run == (o_result.channel == LAST_CH)))
        else $error("last-of-run flag on the wrong channel");

    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (drain_last && !snap_load) |=> !r_busy)
        else $error("snapshot buffer still busy after its last result");
endmodule

/* design/ohlc_chan_update.sv */
// Next open, high, low and close values of one channel for one frame.
// Depends on ohlc_pkg; purely combinational.
module ohlc_chan_update (
    input  ohlc_pkg::t_sample i_sample,
    input  logic              i_opens,
    input  logic              i_closes,
    input  ohlc_pkg::t_ohlc   i_cur,
    output ohlc_pkg::t_ohlc   o_next
);
    import ohlc_pkg::*;

    t_ohlc base;

    always_comb begin
        if (i_opens) begin
            base = '{i_sample, i_sample, i_sample, i_sample};
        end else begin
            base = i_cur;
        end
        o_next = base;
        if (i_sample > base.high_value) begin
            o_next.high_value = i_sample;
        end
        if (i_sample < base.low_value) begin
            o_next.low_value = i_sample;
        end
        if (i_closes) begin
            o_next.close_value = i_sample;
        end
    end
endmodule

/* design/ohlc_result_fmt.sv */
// Bar positions ((v + 32768) * width) >> 16 for the four values of one channel.
// Depends on ohlc_pkg; purely combinational, four narrow multipliers.
module ohlc_result_fmt (
    input  ohlc_pkg::t_ohlc              i_vals,
    input  logic [ohlc_pkg::BAR_W-1:0]   i_bar_width,
    output ohlc_pkg::t_pos               o_pos
);
    import ohlc_pkg::*;

    localparam int PROD_W = SAMPLE_W + BAR_W;

    function automatic logic [POS_W-1:0] bar_pos(input t_sample v, input logic [BAR_W-1:0] w);
        logic [SAMPLE_W-1:0] biased;
        logic [PROD_W-1:0]   prod;
        biased = {~v[SAMPLE_W-1], v[SAMPLE_W-2:0]};
        prod = PROD_W'(biased) * PROD_W'(w);
        return prod[PROD_W-1 -: POS_W];
    endfunction

    assign o_pos.open_pos  = bar_pos(i_vals.open_value, i_bar_width);
    assign o_pos.high_pos  = bar_pos(i_vals.high_value, i_bar_width);
    assign o_pos.low_pos   = bar_pos(i_vals.low_value, i_bar_width);
    assign o_pos.close_pos = bar_pos(i_vals.close_value, i_bar_width);
endmodule
